### rtl/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants for the partition slot allocator
// Request and result layouts, operation and status codes, and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package psa_pkg;

	// number of table slots
	localparam int SLOTS = 4;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int REQ_W = 79;
	localparam int REQ_BYTES_W = 80;
	localparam int RES_W = 80;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_SETBOOT = 3'd2,
		OP_LOAD    = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFREE  = 3'd1,
		ST_OVERLAP = 3'd2,
		ST_BADSLOT = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_INVALID = 3'd5
	} status_t;

	// request item, first field in the highest bits
	typedef struct packed {
		logic        boot_flag;
		logic [31:0] num_sectors;
		logic [31:0] first_sector;
		logic [7:0]  part_type;
		logic [2:0]  slot;
		op_t         op;
	} req_t;

	// result item, first field in the highest bits
	typedef struct packed {
		logic        entry_boot;
		logic [31:0] entry_count;
		logic [31:0] entry_start;
		logic [7:0]  entry_type;
		logic [1:0]  overlap_slot;
		logic [1:0]  slot_out;
		status_t     status;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

### rtl/psa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl: request sequencer
// Takes one item, then runs it through the datapath once the result
// register has room.
// ----------------------------------------------------------------------------
module psa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  psa_pkg::stat_t  stat,
	output psa_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EXEC)
		else $error("capture not followed by execute state");
	a_exec_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> stat.out_free)
		else $error("execute issued while result register full");
	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> !s_tready)
		else $error("item accepted while one is in flight");
`endif

endmodule

### rtl/psa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_dp: partition table datapath
// Request register, slot table, range checks, table update and result
// register.
// ----------------------------------------------------------------------------
module psa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psa_pkg::cmd_t                cmd,
	output psa_pkg::stat_t               stat,
	input  logic [psa_pkg::REQ_W-1:0]    req_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output psa_pkg::res_t                res_out
);

	psa_pkg::req_t req_q;
	psa_pkg::res_t res_q, res_d;
	logic          out_valid_q;

	logic [7:0]  type_q  [psa_pkg::SLOTS];
	logic [31:0] start_q [psa_pkg::SLOTS];
	logic [31:0] len_q   [psa_pkg::SLOTS];
	logic        boot_q  [psa_pkg::SLOTS];

	logic [7:0]  type_d  [psa_pkg::SLOTS];
	logic [31:0] start_d [psa_pkg::SLOTS];
	logic [31:0] len_d   [psa_pkg::SLOTS];
	logic        boot_d  [psa_pkg::SLOTS];

	logic [32:0]              new_s, new_e;
	logic [32:0]              pe      [psa_pkg::SLOTS];
	logic [psa_pkg::SLOTS-1:0] ovl;
	logic                     bad_create, free_any, ovl_any, sl_bad;
	logic [psa_pkg::IDX_W-1:0] free_idx, ovl_idx, sl_idx;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= psa_pkg::req_t'(req_in);
		end
	end

	// range checks against every occupied slot
	always_comb begin
		new_s      = {1'b0, req_q.first_sector};
		new_e      = {1'b0, req_q.first_sector} + {1'b0, req_q.num_sectors};
		bad_create = (req_q.part_type == 8'd0) || (req_q.num_sectors == 32'd0) ||
			new_e[32];
		for (int i = 0; i < psa_pkg::SLOTS; i++) begin
			pe[i]  = {1'b0, start_q[i]} + {1'b0, len_q[i]};
			ovl[i] = (type_q[i] != 8'd0) &&
				((new_s >= {1'b0, start_q[i]} && new_s < pe[i]) ||
				 (new_e > {1'b0, start_q[i]} && new_e <= pe[i]) ||
				 (new_s <= {1'b0, start_q[i]} && new_e >= pe[i]));
		end
	end

	// lowest free slot and lowest overlapping slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		ovl_any  = 1'b0;
		ovl_idx  = '0;
		for (int i = psa_pkg::SLOTS - 1; i >= 0; i--) begin
			if (type_q[i] == 8'd0) begin
				free_any = 1'b1;
				free_idx = psa_pkg::IDX_W'(i);
			end
			if (ovl[i]) begin
				ovl_any = 1'b1;
				ovl_idx = psa_pkg::IDX_W'(i);
			end
		end
	end

	assign sl_bad = 32'(req_q.slot) >= psa_pkg::SLOTS;
	assign sl_idx = psa_pkg::IDX_W'(req_q.slot);

	// table update and result
	always_comb begin
		type_d  = type_q;
		start_d = start_q;
		len_d   = len_q;
		boot_d  = boot_q;
		res_d   = '0;
		res_d.status = psa_pkg::ST_OK;
		case (req_q.op)
			psa_pkg::OP_CREATE: begin
				if (bad_create) begin
					res_d.status = psa_pkg::ST_INVALID;
				end else if (!free_any) begin
					res_d.status = psa_pkg::ST_NOFREE;
				end else if (ovl_any) begin
					res_d.status       = psa_pkg::ST_OVERLAP;
					res_d.overlap_slot = 2'(ovl_idx);
				end else begin
					type_d[free_idx]  = req_q.part_type;
					start_d[free_idx] = req_q.first_sector;
					len_d[free_idx]   = req_q.num_sectors;
					boot_d[free_idx]  = 1'b0;
					res_d.slot_out    = 2'(free_idx);
					res_d.entry_type  = req_q.part_type;
					res_d.entry_start = req_q.first_sector;
					res_d.entry_count = req_q.num_sectors;
				end
			end
			psa_pkg::OP_DELETE, psa_pkg::OP_SETBOOT, psa_pkg::OP_LOAD,
			psa_pkg::OP_READ: begin
				if (sl_bad) begin
					res_d.status = psa_pkg::ST_BADSLOT;
				end else begin
					res_d.slot_out    = 2'(sl_idx);
					res_d.entry_type  = type_q[sl_idx];
					res_d.entry_start = start_q[sl_idx];
					res_d.entry_count = len_q[sl_idx];
					res_d.entry_boot  = boot_q[sl_idx];
					if (req_q.op == psa_pkg::OP_DELETE) begin
						res_d.entry_type  = '0;
						res_d.entry_start = '0;
						res_d.entry_count = '0;
						res_d.entry_boot  = 1'b0;
						if (type_q[sl_idx] == 8'd0) begin
							res_d.status = psa_pkg::ST_EMPTY;
						end else begin
							type_d[sl_idx]  = '0;
							start_d[sl_idx] = '0;
							len_d[sl_idx]   = '0;
							boot_d[sl_idx]  = 1'b0;
						end
					end else if (req_q.op == psa_pkg::OP_SETBOOT) begin
						for (int i = 0; i < psa_pkg::SLOTS; i++) begin
							boot_d[i] = (psa_pkg::IDX_W'(i) == sl_idx);
						end
						res_d.entry_boot = 1'b1;
					end else if (req_q.op == psa_pkg::OP_LOAD) begin
						type_d[sl_idx]    = req_q.part_type;
						start_d[sl_idx]   = req_q.first_sector;
						len_d[sl_idx]     = req_q.num_sectors;
						boot_d[sl_idx]    = req_q.boot_flag;
						res_d.entry_type  = req_q.part_type;
						res_d.entry_start = req_q.first_sector;
						res_d.entry_count = req_q.num_sectors;
						res_d.entry_boot  = req_q.boot_flag;
					end
				end
			end
			default: begin
				res_d.status = psa_pkg::ST_INVALID;
			end
		endcase
	end

	// slot table, empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psa_pkg::SLOTS; i++) begin
				type_q[i]  <= '0;
				start_q[i] <= '0;
				len_q[i]   <= '0;
				boot_q[i]  <= 1'b0;
			end
		end else if (cmd.exec) begin
			type_q  <= type_d;
			start_q <= start_d;
			len_q   <= len_d;
			boot_q  <= boot_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign res_out       = res_q;
	assign stat.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_exec_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("result register not loaded after execute");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.capture))
		else $error("capture and execute in the same cycle");
	a_ovl_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != psa_pkg::ST_OVERLAP |-> res_q.overlap_slot == 2'd0)
		else $error("overlap slot set without overlap status");
	a_fail_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != psa_pkg::ST_OK |-> res_q.entry_type == 8'd0)
		else $error("entry fields set on a failed request");
`endif

endmodule

### rtl/partition_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_slot_allocator: four-slot partition table
// Create, delete, set bootable, load and read requests on a small table
// of partition slots, one result item per request item.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  request item, 80-bit s_tdata
// m_*       out  m_tvalid/m_tready  result item, 80-bit m_tdata
//
// Each item is handled in order: the request is registered, then the four
// slot range checks run and the table and the result register are updated.
// The next item is taken while a result still waits in the output register;
// a stalled output holds the execute step until the register frees.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module partition_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[2:0], slot[5:3], part_type[13:6], first_sector[45:14],
	// num_sectors[77:46], boot_flag[78], zero pad[79]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], slot_out[4:3], overlap_slot[6:5], entry_type[14:7],
	// entry_start[46:15], entry_count[78:47], entry_boot[79]
	output logic [79:0] m_tdata
);

	psa_pkg::cmd_t  cmd;
	psa_pkg::stat_t stat;
	psa_pkg::res_t  res;

	psa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_in    (s_tdata[psa_pkg::REQ_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (res)
	);

	assign m_tdata = psa_pkg::RES_W'(res);

endmodule
